[hdl/renc_pkg.sv]
package renc_pkg;

  typedef struct packed {
    logic        raw_clock;
    logic        raw_data;
    logic        raw_switch;
    logic [31:0] now_ms;
  } renc_in_t;

  typedef struct packed {
    logic signed [1:0]  rotate_step;
    logic               button_pressed;
    logic signed [15:0] position_count;
  } renc_out_t;

  // Current and next debounced levels for the decoder; data next only.
  typedef struct packed {
    logic clock_q;
    logic clock_d;
    logic data_d;
    logic switch_q;
    logic switch_d;
  } renc_lines_t;

  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned CfgDataWidth = 8;

  localparam logic [CfgIdxWidth-1:0] CFG_ROTATION_DEBOUNCE = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_BUTTON_DEBOUNCE   = 8'd1;

  localparam logic [CfgDataWidth-1:0] ROTATION_DEBOUNCE_RESET = 8'd5;
  localparam logic [CfgDataWidth-1:0] BUTTON_DEBOUNCE_RESET   = 8'd20;

  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_UP   = 2'sb01;
  localparam logic signed [1:0] STEP_DOWN = 2'sb11;

endpackage

[hdl/renc_debounce.sv]
module renc_debounce #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                raw_i,
  input  logic [TIME_WIDTH-1:0]               now_i,
  input  logic [renc_pkg::CfgDataWidth-1:0]   limit_i,
  output logic                                stable_o,
  output logic                                stable_next_o
);

  logic                  stable_q, stable_d;
  logic [TIME_WIDTH-1:0] agree_q, agree_d;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  settled;

  // Elapsed time wraps with the timestamp width.
  assign elapsed = now_i - agree_q;
  assign settled = elapsed >= TIME_WIDTH'(limit_i);

  always_comb begin
    stable_d = stable_q;
    agree_d  = agree_q;
    if (raw_i != stable_q) begin
      if (settled) begin
        stable_d = raw_i;
      end
    end else begin
      agree_d = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      agree_q  <= '0;
    end else if (en_i) begin
      stable_q <= stable_d;
      agree_q  <= agree_d;
    end
  end

  assign stable_o      = stable_q;
  assign stable_next_o = stable_d;

endmodule

[hdl/renc_decode.sv]
module renc_decode #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  renc_pkg::renc_lines_t lines_i,
  output renc_pkg::renc_out_t   result_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d, count_step;
  logic                   clock_changed;
  logic                   step_up;
  logic                   press;
  logic signed [1:0]      step;

  assign clock_changed = lines_i.clock_d != lines_i.clock_q;
  assign step_up       = lines_i.data_d != lines_i.clock_d;
  assign press         = lines_i.switch_q & ~lines_i.switch_d;

  always_comb begin
    step       = renc_pkg::STEP_NONE;
    count_step = count_q;
    if (clock_changed) begin
      if (step_up) begin
        step       = renc_pkg::STEP_UP;
        count_step = count_q + COUNT_WIDTH'(1);
      end else begin
        step       = renc_pkg::STEP_DOWN;
        count_step = count_q - COUNT_WIDTH'(1);
      end
    end
    // A press wins over a step in the same beat.
    count_d = press ? '0 : count_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

  assign result_o.rotate_step    = step;
  assign result_o.button_pressed = press;
  assign result_o.position_count = 16'(count_d);

endmodule

[hdl/rotary_encoder_debounce_decode_unit.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_i   (renc_in_t)
// out      output     out_valid_o / out_stall_i  out_o  (renc_out_t)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A beat goes from the input register to the result register, so one beat
// is taken every cycle while the output is not stalled.
// The debounce lines and the step counter update as a beat moves into the
// result register. Reset brings the debounce limits to 5 ms and 20 ms, all
// lines to idle high and the count to zero. A stall on the output holds the
// result register and a full input register, only then raising in_stall_o.
module rotary_encoder_debounce_decode_unit #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  renc_pkg::renc_in_t                   in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output renc_pkg::renc_out_t                  out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [renc_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [renc_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  logic                              in_vld_q;
  renc_pkg::renc_in_t                in_q;
  logic                              out_vld_q;
  renc_pkg::renc_out_t               out_q;
  logic                              advance;
  logic                              work_en;
  logic [renc_pkg::CfgDataWidth-1:0] rot_limit_q, btn_limit_q;
  logic [TIME_WIDTH-1:0]             now;
  renc_pkg::renc_lines_t             lines;
  renc_pkg::renc_out_t               result;
  logic                              clock_q, clock_d, data_q, data_d;
  logic                              switch_q, switch_d;

  assign advance    = ~out_vld_q | ~out_stall_i;
  assign work_en    = in_vld_q & advance;
  assign in_stall_o = in_vld_q & ~advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_i;
    end
  end

  // Configuration must arrive only while idle; the block does not enforce this and is always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_limit_q <= renc_pkg::ROTATION_DEBOUNCE_RESET;
      btn_limit_q <= renc_pkg::BUTTON_DEBOUNCE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        renc_pkg::CFG_ROTATION_DEBOUNCE: rot_limit_q <= cfg_data_i;
        renc_pkg::CFG_BUTTON_DEBOUNCE:   btn_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign now = in_q.now_ms[TIME_WIDTH-1:0];

  renc_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_clock_db (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (work_en),
    .raw_i        (in_q.raw_clock),
    .now_i        (now),
    .limit_i      (rot_limit_q),
    .stable_o     (clock_q),
    .stable_next_o(clock_d)
  );

  renc_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_data_db (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (work_en),
    .raw_i        (in_q.raw_data),
    .now_i        (now),
    .limit_i      (rot_limit_q),
    .stable_o     (data_q),
    .stable_next_o(data_d)
  );

  renc_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_switch_db (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (work_en),
    .raw_i        (in_q.raw_switch),
    .now_i        (now),
    .limit_i      (btn_limit_q),
    .stable_o     (switch_q),
    .stable_next_o(switch_d)
  );

  // The previous stable level always equals the current stable register.
  assign lines.clock_q  = clock_q;
  assign lines.clock_d  = clock_d;
  assign lines.data_d   = data_d;
  assign lines.switch_q = switch_q;
  assign lines.switch_d = switch_d;

  renc_decode #(.COUNT_WIDTH(COUNT_WIDTH)) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (work_en),
    .lines_i (lines),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_en) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  a_press_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.button_pressed |-> out_q.position_count == 16'sd0)
    else $error("press beat with nonzero position");

  a_step_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.rotate_step != 2'sb10)
    else $error("illegal rotate step code");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("stall raised with empty input register");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_vld_q && $stable(in_q))
    else $error("input register changed while stalled");

  a_data_unused_no_dbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_en && clock_d == clock_q |-> result.rotate_step == renc_pkg::STEP_NONE)
    else $error("step reported without clock change");

  a_data_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_en |=> data_q == $past(data_d))
    else $error("data line did not take its next level");

endmodule
